// File: rtl/core/d2jc_pkg.sv
package d2jc_pkg;

  // Field widths
  localparam int DEPTH_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int FRAC_W   = 16;
  localparam int RAMP_W   = 15;

  // Divider layout: two quotient bits per stage
  localparam int BITS_PER_STAGE = 2;
  localparam int NUM_DIV_STAGES = FRAC_W / BITS_PER_STAGE;

  // Constants of the map
  localparam logic [DEPTH_W-1:0] RANGE_RESET = 16'd8450;
  localparam logic [COLOR_W-1:0] GREY        = 8'd40;
  localparam logic [COLOR_W-1:0] FULL_ON     = 8'd255;
  localparam logic [COLOR_W-1:0] FULL_OFF    = 8'd0;
  localparam logic [FRAC_W:0]    FULL_SCALE  = 17'h10000;
  localparam logic [RAMP_W-1:0]  SEG_LEN     = 15'd16384;

  // Which component takes the ramp value
  typedef enum logic [1:0] {
    RAMP_NONE,
    RAMP_RED,
    RAMP_GREEN,
    RAMP_BLUE
  } ramp_ch_t;

  // Word moving through the divider stages
  typedef struct packed {
    logic               valid;
    logic               grey;
    logic               sat;
    logic [DEPTH_W-1:0] rem;
    logic [FRAC_W-1:0]  quo;
  } div_word_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  // Caller keeps rem < divisor, so the new remainder fits in DEPTH_W bits.
  function automatic logic [DEPTH_W:0] div_step(input logic [DEPTH_W-1:0] rem,
                                                input logic [DEPTH_W-1:0] dvs);
    logic [DEPTH_W:0] shifted;
    logic [DEPTH_W:0] diff;
    logic             ge;
    shifted = {rem, 1'b0};
    diff    = shifted - {1'b0, dvs};
    ge      = (shifted >= {1'b0, dvs});
    return ge ? {1'b1, diff[DEPTH_W-1:0]} : {1'b0, shifted[DEPTH_W-1:0]};
  endfunction

endpackage

// File: rtl/core/d2jc_div_stage.sv
module d2jc_div_stage
  import d2jc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [DEPTH_W-1:0] divisor,
  input  div_word_t          din,
  output div_word_t          dout
);

  logic [DEPTH_W:0]       step_res [BITS_PER_STAGE];
  logic [BITS_PER_STAGE-1:0] qbits;
  logic                   valid;
  logic                   grey;
  logic                   sat;
  logic [DEPTH_W-1:0]     rem;
  logic [FRAC_W-1:0]      quo;

  // Chain of restoring steps, MSB of this stage's quotient bits first
  always_comb begin
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      if (i == 0) begin
        step_res[i] = div_step(din.rem, divisor);
      end else begin
        step_res[i] = div_step(step_res[i-1][DEPTH_W-1:0], divisor);
      end
      qbits[BITS_PER_STAGE-1-i] = step_res[i][DEPTH_W];
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= din.valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      grey <= din.grey;
      sat  <= din.sat;
      rem  <= step_res[BITS_PER_STAGE-1][DEPTH_W-1:0];
      quo  <= {din.quo[FRAC_W-BITS_PER_STAGE-1:0], qbits};
    end
  end

  assign dout = '{valid: valid, grey: grey, sat: sat, rem: rem, quo: quo};

endmodule

// File: rtl/core/d2jc_colour_map.sv
module d2jc_colour_map
  import d2jc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  div_word_t          din,
  output logic               out_valid,
  output logic [COLOR_W-1:0] red,
  output logic [COLOR_W-1:0] green,
  output logic [COLOR_W-1:0] blue
);

  // Segment codes from the top bits of v
  localparam logic [2:0] SEG_BLUE_GREEN = 3'd0;
  localparam logic [2:0] SEG_GREEN_BLUE = 3'd1;
  localparam logic [2:0] SEG_GREEN_RED  = 3'd2;
  localparam logic [2:0] SEG_RED_GREEN  = 3'd3;

  logic [FRAC_W:0]    v;
  logic [RAMP_W-1:0]  t_rise;
  logic [RAMP_W-1:0]  t_fall;
  logic [COLOR_W-1:0] base_r_next, base_g_next, base_b_next;
  logic [RAMP_W-1:0]  arg_next;
  ramp_ch_t           ch_next;

  logic               s1_valid;
  logic [COLOR_W-1:0] base_r, base_g, base_b;
  logic [RAMP_W-1:0]  arg;
  ramp_ch_t           ch;

  logic [RAMP_W+COLOR_W-1:0] prod;
  logic [COLOR_W-1:0]        ramp_val;

  // Stage 1: invert the fraction and pick the segment
  always_comb begin
    v      = din.sat ? '0 : (FULL_SCALE - {1'b0, din.quo});
    t_rise = {1'b0, v[RAMP_W-2:0]};
    t_fall = SEG_LEN - t_rise;
    base_r_next = FULL_OFF;
    base_g_next = FULL_OFF;
    base_b_next = FULL_OFF;
    arg_next    = '0;
    ch_next     = RAMP_NONE;
    if (din.grey) begin
      base_r_next = GREY;
      base_g_next = GREY;
      base_b_next = GREY;
    end else begin
      case (v[FRAC_W:RAMP_W-1])
        SEG_BLUE_GREEN: begin
          base_b_next = FULL_ON;
          ch_next     = RAMP_GREEN;
          arg_next    = t_rise;
        end
        SEG_GREEN_BLUE: begin
          base_g_next = FULL_ON;
          ch_next     = RAMP_BLUE;
          arg_next    = t_fall;
        end
        SEG_GREEN_RED: begin
          base_g_next = FULL_ON;
          ch_next     = RAMP_RED;
          arg_next    = t_rise;
        end
        SEG_RED_GREEN: begin
          base_r_next = FULL_ON;
          ch_next     = RAMP_GREEN;
          arg_next    = t_fall;
        end
        default: begin
          // v at full scale: red with green at zero
          base_r_next = FULL_ON;
          ch_next     = RAMP_GREEN;
          arg_next    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= din.valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r <= base_r_next;
      base_g <= base_g_next;
      base_b <= base_b_next;
      arg    <= arg_next;
      ch     <= ch_next;
    end
  end

  // Stage 2: ramp = floor(arg * 255 / 16384), then merge into the colour
  assign prod     = {arg, {COLOR_W{1'b0}}} - {{COLOR_W{1'b0}}, arg};
  assign ramp_val = prod[RAMP_W+COLOR_W-2:RAMP_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= (ch == RAMP_RED)   ? ramp_val : base_r;
      green <= (ch == RAMP_GREEN) ? ramp_val : base_g;
      blue  <= (ch == RAMP_BLUE)  ? ramp_val : base_b;
    end
  end

  // Grey only comes as a whole word (a red ramp at 40 always has green full on)
  a_grey_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid && red == GREY && green != FULL_ON |-> green == GREY && blue == GREY)
    else $error("partial grey word");

  // Any jet colour has one component at full scale
  a_jet_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && red != GREY |-> red == FULL_ON || green == FULL_ON || blue == FULL_ON)
    else $error("jet colour without a saturated component");

  // Any jet colour has red or blue off
  a_jet_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && red != GREY |-> red == FULL_OFF || blue == FULL_OFF)
    else $error("jet colour with both red and blue lit");

endmodule

// File: rtl/core/depth_to_jet_colour.sv
// Pipeline: 8 divider stages at two quotient bits each, then 2 colour map stages,
// from input word accepted to output word shown.
// Throughput: one word per cycle; the whole pipe holds while the output word stalls.
// Reset (rst, synchronous): clears all valid bits; the range register returns to 8450.
module depth_to_jet_colour
  import d2jc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DEPTH_W-1:0] depth_mm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] red,
  output logic [COLOR_W-1:0] green,
  output logic [COLOR_W-1:0] blue,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [DEPTH_W-1:0] max_range
);

  logic [DEPTH_W-1:0] range_reg;
  logic               en;
  div_word_t          div_pipe [NUM_DIV_STAGES+1];

  // Range register, zero maps to one
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_reg <= RANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      range_reg <= (max_range == '0) ? DEPTH_W'(1) : max_range;
    end
  end

  // Pipe advances unless the output word is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Entry: q saturates when depth reaches the range
  assign div_pipe[0] = '{valid: in_valid && en,
                         grey:  (depth_mm == '0),
                         sat:   (depth_mm >= range_reg),
                         rem:   depth_mm,
                         quo:   '0};

  for (genvar i = 0; i < NUM_DIV_STAGES; i++) begin : g_div
    d2jc_div_stage u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .divisor (range_reg),
      .din     (div_pipe[i]),
      .dout    (div_pipe[i+1])
    );
  end

  d2jc_colour_map u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .din       (div_pipe[NUM_DIV_STAGES]),
    .out_valid (out_valid),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  // Range never holds zero
  a_range_nonzero: assert property (@(posedge clk) disable iff (rst)
    range_reg != '0)
    else $error("range register holds zero");

  // Input stalls exactly when the output word is held
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall out of step with output");

  // A word not taken stays valid at the output
  a_out_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output word dropped");

endmodule

// File: dv/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import d2jc_pkg::*;

  localparam int PIPE_LAT    = 10;
  localparam int HOLD_CYCLES = 40;
  localparam int PHASE_WORDS = 204;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  typedef enum logic {ROW_WORD, ROW_RANGE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    bit                 pinned;
    logic [DEPTH_W-1:0] val;
    rgb_t               colour;
  } dir_row_t;

  localparam rgb_t GREY_RGB = '{GREY, GREY, GREY};
  localparam rgb_t BLUE_RGB = '{FULL_OFF, FULL_OFF, FULL_ON};
  localparam rgb_t NO_RGB   = '{FULL_OFF, FULL_OFF, FULL_OFF};

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [DEPTH_W-1:0] depth_mm;
  logic               out_valid;
  logic               out_stall;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [DEPTH_W-1:0] max_range;

  // testbench copy of the range register
  logic [DEPTH_W-1:0] range_now;
  rgb_t               colour_queue[$];
  int                 err_cnt;
  int                 words_sent;
  int                 colours_seen;
  int                 ranges_set;
  bit                 quiet;
  bit                 hold_req;

  depth_to_jet_colour u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .depth_mm  (depth_mm),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .max_range (max_range)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // jet colour of one depth at the current range
  function automatic rgb_t jet_colour(logic [DEPTH_W-1:0] d, logic [DEPTH_W-1:0] rng);
    longint unsigned frac;
    longint unsigned heat;
    rgb_t            c;
    c = NO_RGB;
    if (d == '0) begin
      return GREY_RGB;
    end
    frac = (longint'(d) << 16) / longint'(rng);
    if (frac > 65536) frac = 65536;
    heat = 65536 - frac;
    // four ramps of 16384 each, hot end at heat = 65536
    if (heat < 16384) begin
      c.b = FULL_ON;
      c.g = COLOR_W'((heat * 255) >> 14);
    end else if (heat < 32768) begin
      c.g = FULL_ON;
      c.b = COLOR_W'(((32768 - heat) * 255) >> 14);
    end else if (heat < 49152) begin
      c.g = FULL_ON;
      c.r = COLOR_W'(((heat - 32768) * 255) >> 14);
    end else begin
      c.r = FULL_ON;
      c.g = COLOR_W'(((65536 - heat) * 255) >> 14);
    end
    return c;
  endfunction

  // mostly depths inside full scale, some zero, some past it, some near ramp breaks
  function automatic logic [DEPTH_W-1:0] pick_depth(logic [DEPTH_W-1:0] rng);
    int unsigned base;
    int          d;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DEPTH_W'($urandom);
      2: return DEPTH_W'($urandom_range(int'(rng), 65535));
      3: begin
        base = (int'(rng) * $urandom_range(1, 3)) / 4;
        d = int'(base) + $urandom_range(0, 6) - 3;
        if (d < 1) d = 1;
        if (d > 65535) d = 65535;
        return DEPTH_W'(d);
      end
      default: return DEPTH_W'($urandom_range(1, int'(rng)));
    endcase
  endfunction

  // offer one word, with an optional gap first; pinned colour overrides the predictor
  task automatic send_depth(logic [DEPTH_W-1:0] d, bit pinned, rgb_t pin_colour);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    depth_mm <= d;
    do @(posedge clk); while (in_stall);
    colour_queue.push_back(pinned ? pin_colour : jet_colour(d, range_now));
    words_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // register write, only called with the pipe empty
  task automatic write_range(logic [DEPTH_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    max_range <= v;
    do @(posedge clk); while (!cfg_ready);
    range_now = (v == '0) ? DEPTH_W'(1) : v;
    ranges_set++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // output side: random stall bursts, plus one long hold when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // compare each colour word against the oldest prediction
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      colours_seen++;
      if (colour_queue.size() == 0) begin
        $display("%0t: unexpected colour word r=%0d g=%0d b=%0d", $time, red, green, blue);
        err_cnt++;
      end else begin
        want = colour_queue.pop_front();
        if (red !== want.r) begin
          $display("%0t: red expected %0d actual %0d", $time, want.r, red);
          err_cnt++;
        end
        if (green !== want.g) begin
          $display("%0t: green expected %0d actual %0d", $time, want.g, green);
          err_cnt++;
        end
        if (blue !== want.b) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.b, blue);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d colour words still expected", colour_queue.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    dir_row_t dir_rows[] = '{
      '{ROW_WORD,  1'b1, 16'd0,     GREY_RGB},
      '{ROW_WORD,  1'b0, 16'd1,     NO_RGB},
      '{ROW_WORD,  1'b0, 16'd4225,  NO_RGB},
      '{ROW_WORD,  1'b0, 16'd8449,  NO_RGB},
      '{ROW_WORD,  1'b1, 16'd8450,  BLUE_RGB},
      '{ROW_WORD,  1'b1, 16'd65535, BLUE_RGB},
      '{ROW_RANGE, 1'b0, 16'd0,     NO_RGB},
      '{ROW_WORD,  1'b1, 16'd1,     BLUE_RGB},
      '{ROW_WORD,  1'b1, 16'd0,     GREY_RGB},
      '{ROW_WORD,  1'b1, 16'd65535, BLUE_RGB},
      '{ROW_RANGE, 1'b0, 16'd4,     NO_RGB},
      '{ROW_WORD,  1'b0, 16'd1,     NO_RGB},
      '{ROW_WORD,  1'b0, 16'd2,     NO_RGB},
      '{ROW_WORD,  1'b0, 16'd3,     NO_RGB},
      '{ROW_WORD,  1'b1, 16'd4,     BLUE_RGB},
      '{ROW_RANGE, 1'b0, 16'd65535, NO_RGB},
      '{ROW_WORD,  1'b0, 16'd1,     NO_RGB},
      '{ROW_WORD,  1'b0, 16'd16384, NO_RGB},
      '{ROW_WORD,  1'b0, 16'd32768, NO_RGB},
      '{ROW_WORD,  1'b0, 16'd49151, NO_RGB},
      '{ROW_WORD,  1'b0, 16'd65534, NO_RGB},
      '{ROW_WORD,  1'b1, 16'd65535, BLUE_RGB},
      '{ROW_RANGE, 1'b0, 16'd1,     NO_RGB},
      '{ROW_WORD,  1'b1, 16'h8000,  BLUE_RGB}
    };
    logic [DEPTH_W-1:0] phase_range[8];
    rst          = 1'b1;
    in_valid     = 1'b0;
    depth_mm     = '0;
    cfg_valid    = 1'b0;
    max_range    = '0;
    range_now    = RANGE_RESET;
    err_cnt      = 0;
    words_sent   = 0;
    colours_seen = 0;
    ranges_set   = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset range first, then the range extremes and exact ramp breaks
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_RANGE) begin
        drain();
        write_range(dir_rows[i].val);
      end else begin
        send_depth(dir_rows[i].val, dir_rows[i].pinned, dir_rows[i].colour);
      end
    end
    drain();

    // random phases, one range each; long output hold in the second,
    // no idling in the last
    phase_range[0] = RANGE_RESET;
    phase_range[1] = DEPTH_W'($urandom_range(100, 65535));
    phase_range[2] = 16'hFFFF;
    phase_range[3] = DEPTH_W'($urandom_range(1, 63));
    phase_range[4] = '0;
    phase_range[5] = DEPTH_W'($urandom);
    phase_range[6] = DEPTH_W'($urandom_range(2, 4));
    phase_range[7] = DEPTH_W'($urandom_range(1000, 20000));
    foreach (phase_range[p]) begin
      write_range(phase_range[p]);
      if (p == 1) hold_req = 1'b1;
      if (p == 7) quiet = 1'b1;
      repeat (PHASE_WORDS) send_depth(pick_depth(range_now), 1'b0, NO_RGB);
      drain();
    end

    $display("Sent %0d depth words over %0d max_range writes (zero, one, full scale, random),",
             words_sent, ranges_set);
    $display("compared %0d colour words, with stall bursts and a %0d-cycle output hold.",
             colours_seen, HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: depth_to_jet_colour.f
rtl/core/d2jc_pkg.sv
rtl/core/d2jc_div_stage.sv
rtl/core/d2jc_colour_map.sv
rtl/core/depth_to_jet_colour.sv
dv/tb_top.sv
